>>> design/qfc_pkg.sv
// Package for the quadratic form cube block: sequencer codes and ALU operation codes.
package qfc_pkg;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV,
      ALU_REM
   } alu_op_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_EU_INIT,
      ST_EU_TEST,
      ST_EU_DIV,
      ST_EU_R,
      ST_EU_S,
      ST_EU_T,
      ST_EU_FIX,
      ST_EU_DONE,
      ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8, ST_F9, ST_F10,
      ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5, ST_G6, ST_G7, ST_G8, ST_G9, ST_G10,
      ST_G11, ST_G12, ST_G13, ST_G14,
      ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7,
      ST_WAIT,
      ST_OUT
   } state_type;

   // Operation request from the sequencer to the shared ALU.
   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

endpackage

>>> design/qfc_alu.sv
// Shared word ALU: add and subtract registered in the cycle after the request, iterative multiply and divide.
module qfc_alu
   import qfc_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  alu_req_type          req,
   input  logic [WORD_BITS-1:0] opa,
   input  logic [WORD_BITS-1:0] opb,
   output logic                 done,
   output logic [WORD_BITS-1:0] result
);

   localparam int CW = $clog2(WORD_BITS + 1);
   localparam int HB = WORD_BITS / 2;

   logic                 busy_ff, busy_in;
   alu_op_type           op_ff, op_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] x_ff, x_in;       // multiplicand / dividend magnitude
   logic [WORD_BITS-1:0] y_ff, y_in;       // multiplier / divisor magnitude
   logic [WORD_BITS-1:0] acc_ff, acc_in;   // product / remainder
   logic [WORD_BITS-1:0] q_ff, q_in;
   logic                 nq_ff, nq_in, nr_ff, nr_in, zero_ff, zero_in;
   logic [WORD_BITS-1:0] res_ff, res_in;
   logic                 done_ff, done_in;

   logic                 na, nb;
   logic [WORD_BITS-1:0] ma, mb;
   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS-1:0] rsh;
   logic [WORD_BITS-1:0] part;

   assign done   = done_ff;
   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      q_ff    <= q_in;
      nq_ff   <= nq_in;
      nr_ff   <= nr_in;
      zero_ff <= zero_in;
      res_ff  <= res_in;
   end

   always_comb begin
      na      = opa[WORD_BITS-1];
      nb      = opb[WORD_BITS-1];
      ma      = na ? (~opa + 1'b1) : opa;
      mb      = nb ? (~opb + 1'b1) : opb;
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      nq_in   = nq_ff;
      nr_in   = nr_ff;
      zero_in = zero_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      rsh     = {acc_ff[WORD_BITS-2:0], x_ff[WORD_BITS-1]};
      trial   = {1'b0, rsh} - {1'b0, y_ff};
      // two multiplier bits per cycle, low half of the product only
      part    = (y_ff[0] ? x_ff : '0) + (y_ff[1] ? {x_ff[WORD_BITS-2:0], 1'b0} : '0);
      if (req.start) begin
         op_in = req.op;
         unique case (req.op)
            ALU_ADD: begin
               res_in  = opa + opb;
               done_in = 1'b1;
            end
            ALU_SUB: begin
               res_in  = opa - opb;
               done_in = 1'b1;
            end
            ALU_MUL: begin
               busy_in = 1'b1;
               x_in    = opa;
               y_in    = opb;
               acc_in  = '0;
               cnt_in  = CW'(HB);
            end
            default: begin
               busy_in = 1'b1;
               x_in    = ma;
               y_in    = mb;
               acc_in  = '0;
               q_in    = '0;
               nq_in   = na ^ nb;
               nr_in   = na;
               zero_in = (opb == '0);
               cnt_in  = CW'(WORD_BITS);
               res_in  = opa;
            end
         endcase
      end else if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            acc_in = acc_ff + part;
            x_in   = {x_ff[WORD_BITS-3:0], 2'b00};
            y_in   = {2'b00, y_ff[WORD_BITS-1:2]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               res_in  = acc_ff + part;
            end
         end else if (zero_ff) begin
            // quotient 0, remainder = dividend (already held in res)
            busy_in = 1'b0;
            done_in = 1'b1;
            if (op_ff == ALU_DIV) begin
               res_in = '0;
            end
         end else begin
            x_in = {x_ff[WORD_BITS-2:0], 1'b0};
            if (!trial[WORD_BITS]) begin
               acc_in = trial[WORD_BITS-1:0];
               q_in   = {q_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               acc_in = rsh;
               q_in   = {q_ff[WORD_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               if (op_ff == ALU_DIV) begin
                  res_in = nq_ff ? (~q_in + 1'b1) : q_in;
               end else begin
                  res_in = nr_ff ? (~acc_in + 1'b1) : acc_in;
               end
            end
         end
      end
   end

endmodule

>>> design/quadratic_form_cube.sv
// Top level of the quadratic form cube block: stream ports and micro-sequencer.
//
// Cubes a binary quadratic form (a, b, c) into an unreduced form (A, B, C) using
// one shared word ALU (registered add/subtract, 2-bit-per-cycle multiply, radix-2
// restoring divide) driven by a small sequencer. One form is in flight at a time:
// req_tready is high only while the block is idle. Each extended Euclid step is one
// divide, three multiplies and one update state. Latency is data dependent; the
// longest forms take two Euclid runs plus the reduction chain. The result is held in
// an output register and leaves on the rsp_ channel; a new form is taken only after
// that transfer. All arithmetic wraps on WORD_BITS bits; results are sign-extended
// to 64 bits and then cut to their field widths.
module quadratic_form_cube
   import qfc_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // form_a[19:0], form_b[40:20], form_c[80:41], zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata    // cube_a[59:0], cube_b[123:60], cube_c[187:124], zero fill
);

   localparam int W = WORD_BITS;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;      // resume point after an ALU wait
   logic      pass_ff, pass_in;    // second Euclid run

   // working registers
   logic [W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [W-1:0] r0_ff, r0_in, r1_ff, r1_in, s0_ff, s0_in, s1_ff, s1_in;
   logic [W-1:0] t0_ff, t0_in, t1_ff, t1_in, q_ff, q_in, tmp_ff, tmp_in;
   logic [W-1:0] v1_ff, v1_in, u2_ff, u2_in, v2_ff, v2_in, g_ff, g_in;
   logic [W-1:0] n_ff, n_in, l_ff, l_in, k_ff, k_in, x_ff, x_in;
   logic [W-1:0] oa_ff, oa_in, ob_ff, ob_in;

   alu_req_type  alu_req;
   logic [W-1:0] alu_a, alu_b, alu_res;
   logic         alu_done;

   logic [W-1:0] fa, fb, fc;
   logic [63:0]  ra, rb, rc;

   qfc_alu #(.WORD_BITS(W)) u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   // unpack input fields to the word: a and c zero-extended, b sign-extended
   always_comb begin
      fa = W'({44'd0, req_tdata[19:0]});
      fb = W'({{43{req_tdata[40]}}, req_tdata[40:20]});
      fc = W'({24'd0, req_tdata[80:41]});
      ra = 64'(signed'(oa_ff));
      rb = 64'(signed'(ob_ff));
      rc = 64'(signed'(x_ff));
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {4'd0, rc, rb, ra[59:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pass_ff  <= pass_in;
      end
      a_ff <= a_in;   b_ff <= b_in;   c_ff <= c_in;
      r0_ff <= r0_in; r1_ff <= r1_in; s0_ff <= s0_in; s1_ff <= s1_in;
      t0_ff <= t0_in; t1_ff <= t1_in; q_ff <= q_in;   tmp_ff <= tmp_in;
      v1_ff <= v1_in; u2_ff <= u2_in; v2_ff <= v2_in; g_ff <= g_in;
      n_ff <= n_in;   l_ff <= l_in;   k_ff <= k_in;   x_ff <= x_in;
      oa_ff <= oa_in; ob_ff <= ob_in;
   end

   // Sequencer. Most steps issue one ALU op and park in ST_WAIT; the result is
   // latched into the destination by the step named in ret_ff on return.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      pass_in  = pass_ff;
      a_in = a_ff;   b_in = b_ff;   c_in = c_ff;
      r0_in = r0_ff; r1_in = r1_ff; s0_in = s0_ff; s1_in = s1_ff;
      t0_in = t0_ff; t1_in = t1_ff; q_in = q_ff;   tmp_in = tmp_ff;
      v1_in = v1_ff; u2_in = u2_ff; v2_in = v2_ff; g_in = g_ff;
      n_in = n_ff;   l_in = l_ff;   k_in = k_ff;   x_in = x_ff;
      oa_in = oa_ff; ob_in = ob_ff;
      alu_req = '{start: 1'b0, op: ALU_ADD};
      alu_a   = '0;
      alu_b   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               a_in  = fa;
               b_in  = fb;
               c_in  = fc;
               r0_in = fb;
               r1_in = fa;
               pass_in  = 1'b0;
               state_in = ST_EU_INIT;
            end
         end
         // ---------------- extended Euclid on (r0, r1) ----------------
         ST_EU_INIT: begin
            s0_in = W'(1); s1_in = '0; t0_in = '0; t1_in = W'(1);
            state_in = ST_EU_TEST;
         end
         ST_EU_TEST: begin
            if (r1_ff == '0) begin
               state_in = ST_EU_FIX;
            end else begin
               alu_req  = '{start: 1'b1, op: ALU_DIV};
               alu_a    = r0_ff; alu_b = r1_ff;
               ret_in   = ST_EU_DIV;
               state_in = ST_WAIT;
            end
         end
         ST_EU_DIV: begin
            q_in     = alu_res;
            alu_req  = '{start: 1'b1, op: ALU_MUL};
            alu_a    = alu_res; alu_b = r1_ff;
            ret_in   = ST_EU_R;
            state_in = ST_WAIT;
         end
         ST_EU_R: begin
            r0_in = r1_ff;
            r1_in = r0_ff - alu_res;
            alu_req  = '{start: 1'b1, op: ALU_MUL};
            alu_a    = q_ff; alu_b = s1_ff;
            ret_in   = ST_EU_S;
            state_in = ST_WAIT;
         end
         ST_EU_S: begin
            s0_in = s1_ff;
            s1_in = s0_ff - alu_res;
            alu_req  = '{start: 1'b1, op: ALU_MUL};
            alu_a    = q_ff; alu_b = t1_ff;
            ret_in   = ST_EU_T;
            state_in = ST_WAIT;
         end
         ST_EU_T: begin
            t0_in = t1_ff;
            t1_in = t0_ff - alu_res;
            state_in = ST_EU_TEST;
         end
         ST_EU_FIX: begin
            if (r0_ff[W-1]) begin
               r0_in = ~r0_ff + 1'b1;
               s0_in = ~s0_ff + 1'b1;
               t0_in = ~t0_ff + 1'b1;
            end
            state_in = ST_EU_DONE;
         end
         ST_EU_DONE: begin
            if (!pass_ff) begin
               g_in  = r0_ff;
               v1_in = s0_ff;
               if (r0_ff == W'(1)) begin
                  n_in = a_ff;
                  state_in = ST_F0;
               end else begin
                  state_in = ST_G0;
               end
            end else begin
               g_in  = r0_ff;        // S
               u2_in = s0_ff;
               v2_in = t0_ff;
               state_in = ST_G5;
            end
         end
         // ---------------- fast path ----------------
         ST_F0: begin
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = a_ff; alu_b = a_ff;
            ret_in = ST_F1; state_in = ST_WAIT;
         end
         ST_F1: begin
            l_in = alu_res;
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = v1_ff; alu_b = alu_res;
            ret_in = ST_F2; state_in = ST_WAIT;
         end
         ST_F2: begin
            v1_in = alu_res;
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = alu_res; alu_b = c_ff;
            ret_in = ST_F3; state_in = ST_WAIT;
         end
         ST_F3: begin
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = alu_res; alu_b = l_ff;
            ret_in = ST_F4; state_in = ST_WAIT;
         end
         ST_F4: begin
            tmp_in = alu_res;
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = alu_res; alu_b = a_ff;
            ret_in = ST_F5; state_in = ST_WAIT;
         end
         ST_F5: begin
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = alu_res; alu_b = l_ff;
            ret_in = ST_F6; state_in = ST_WAIT;
         end
         ST_F6: begin
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = b_ff - alu_res; alu_b = v1_ff;
            ret_in = ST_F7; state_in = ST_WAIT;
         end
         ST_F7: begin
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = alu_res; alu_b = l_ff;
            ret_in = ST_F8; state_in = ST_WAIT;
         end
         ST_F8: begin
            alu_req = '{start: 1'b1, op: ALU_MUL};
            alu_a = alu_res - W'(2); alu_b = tmp_ff;
            ret_in = ST_F9; state_in = ST_WAIT;
         end
         ST_F9: begin
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = alu_res; alu_b = l_ff;
            ret_in = ST_F10; state_in = ST_WAIT;
         end
         ST_F10: begin
            k_in = alu_res;
            state_in = ST_T0;
         end
         // ---------------- general path ----------------
         ST_G0: begin
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = g_ff; alu_b = a_ff;
            ret_in = ST_G1; state_in = ST_WAIT;
         end
         ST_G1: begin
            r0_in = alu_res;   // g1*a
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = b_ff; alu_b = b_ff;
            ret_in = ST_G2; state_in = ST_WAIT;
         end
         ST_G2: begin
            tmp_in = alu_res;
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = a_ff; alu_b = c_ff;
            ret_in = ST_G3; state_in = ST_WAIT;
         end
         ST_G3: begin
            r1_in = tmp_ff - alu_res;
            pass_in = 1'b1;
            state_in = ST_EU_INIT;
         end
         ST_G5: begin
            alu_req = '{start: 1'b1, op: ALU_DIV}; alu_a = a_ff; alu_b = g_ff;
            ret_in = ST_G6; state_in = ST_WAIT;
         end
         ST_G6: begin
            n_in = alu_res;
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = alu_res; alu_b = a_ff;
            ret_in = ST_G7; state_in = ST_WAIT;
         end
         ST_G7: begin
            l_in = alu_res;
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = v2_ff; alu_b = alu_res;
            ret_in = ST_G8; state_in = ST_WAIT;
         end
         ST_G8: begin
            v2_in = alu_res;
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = v1_ff; alu_b = u2_ff;
            ret_in = ST_G9; state_in = ST_WAIT;
         end
         ST_G9: begin
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = alu_res; alu_b = l_ff;
            ret_in = ST_G10; state_in = ST_WAIT;
         end
         ST_G10: begin
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = alu_res; alu_b = a_ff;
            ret_in = ST_G11; state_in = ST_WAIT;
         end
         ST_G11: begin
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = alu_res; alu_b = l_ff;
            ret_in = ST_G12; state_in = ST_WAIT;
         end
         ST_G12: begin
            k_in = alu_res;
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = v2_ff; alu_b = b_ff;
            ret_in = ST_G13; state_in = ST_WAIT;
         end
         ST_G13: begin
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = alu_res; alu_b = l_ff;
            ret_in = ST_G14; state_in = ST_WAIT;
         end
         ST_G14: begin
            // k + (v2*b mod L), then times c mod L
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = k_ff + alu_res; alu_b = c_ff;
            ret_in = ST_G4; state_in = ST_WAIT;
         end
         ST_G4: begin
            alu_req = '{start: 1'b1, op: ALU_REM}; alu_a = alu_res; alu_b = l_ff;
            ret_in = ST_T7; state_in = ST_WAIT;
         end
         ST_T7: begin
            // k = L - k, then scale c by S
            k_in = l_ff - alu_res;
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = c_ff; alu_b = g_ff;
            ret_in = ST_T6; state_in = ST_WAIT;
         end
         ST_T6: begin
            c_in = alu_res;
            state_in = ST_T0;
         end
         // ---------------- final composition ----------------
         ST_T0: begin
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = n_ff; alu_b = k_ff;
            ret_in = ST_T1; state_in = ST_WAIT;
         end
         ST_T1: begin
            tmp_in = alu_res;   // t = N*K
            ob_in  = {alu_res[W-2:0], 1'b0} + b_ff;
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = n_ff; alu_b = l_ff;
            ret_in = ST_T2; state_in = ST_WAIT;
         end
         ST_T2: begin
            oa_in = alu_res;
            alu_req = '{start: 1'b1, op: ALU_MUL}; alu_a = tmp_ff + b_ff; alu_b = k_ff;
            ret_in = ST_T3; state_in = ST_WAIT;
         end
         ST_T3: begin
            alu_req = '{start: 1'b1, op: ALU_DIV}; alu_a = alu_res + c_ff; alu_b = l_ff;
            ret_in = ST_T4; state_in = ST_WAIT;
         end
         ST_T4: begin
            x_in = alu_res;
            state_in = ST_OUT;
         end
         ST_T5: begin
            state_in = ST_OUT;
         end
         ST_WAIT: begin
            if (alu_done) begin
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> bench/tb_quadratic_form_cube.sv
// Testbench for quadratic_form_cube: directed and random forms checked against a predictor.
`timescale 1ns / 100ps

module tb_quadratic_form_cube;
   import qfc_pkg::*;

   localparam int WORD_BITS = 64;
   localparam int RANDOM_FORMS = 1500;

   typedef struct packed {
      logic [39:0] form_c;
      logic [20:0] form_b;
      logic [19:0] form_a;
   } form_type;

   typedef struct packed {
      logic [63:0] cube_c;
      logic [63:0] cube_b;
      logic [59:0] cube_a;
   } cube_type;

   // One directed row: the form, and optionally a typed-in expected cube.
   typedef struct {
      logic [19:0] a;
      logic [20:0] b;
      logic [39:0] c;
      bit          typed;
      cube_type    cube;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;   // form_a[19:0], form_b[40:20], form_c[80:41], zero fill
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;        // cube_a[59:0], cube_b[123:60], cube_c[187:124], zero fill

   cube_type cube_queue[$];
   int       mismatches = 0;
   int       forms_sent = 0;
   int       cubes_seen = 0;
   int       fast_forms = 0;
   bit       calm = 1'b0;          // set during the stretch without idling

   always #10 clock = ~clock;

   quadratic_form_cube #(.WORD_BITS(WORD_BITS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Word arithmetic: 64-bit two's complement with C-style truncating division.
   function automatic longint word_div(longint x, longint y);
      if (y == 0) return 0;
      if (x == 64'sh8000_0000_0000_0000 && y == -1) return x;
      return x / y;
   endfunction

   function automatic longint word_rem(longint x, longint y);
      if (y == 0) return x;
      return x - word_div(x, y) * y;
   endfunction

   // Extended Euclid: g = s*x + t*y, gcd forced non-negative.
   task automatic bezout(input longint x, input longint y,
                         output longint g, output longint s, output longint t);
      longint r0, r1, s0, s1, t0, t1, q, r2, s2, t2;
      r0 = x; r1 = y; s0 = 1; s1 = 0; t0 = 0; t1 = 1;
      while (r1 != 0) begin
         q  = word_div(r0, r1);
         r2 = r0 - q * r1;
         s2 = s0 - q * s1;
         t2 = t0 - q * t1;
         r0 = r1; r1 = r2;
         s0 = s1; s1 = s2;
         t0 = t1; t1 = t2;
      end
      if (r0 < 0) begin
         r0 = -r0; s0 = -s0; t0 = -t0;
      end
      g = r0; s = s0; t = t0;
   endtask

   // Compute the unreduced cube of one form.
   task automatic cube_form(input form_type f, output cube_type r, output bit fast);
      longint a, b, c, g1, v1, u1, n, l, k, t, tmp, sp, disc, s, u2, v2;
      a = longint'(f.form_a);
      b = longint'(signed'(f.form_b));
      c = longint'(f.form_c);
      bezout(b, a, g1, v1, u1);
      fast = (g1 == 1);
      if (fast) begin
         n   = a;
         l   = a * a;
         v1  = word_rem(v1, l);
         tmp = word_rem(v1 * c, l);
         k   = word_rem(tmp * a, l);
         k   = word_rem((b - k) * v1, l);
         k   = word_rem((k - 2) * tmp, l);
      end else begin
         sp   = g1 * a;
         disc = b * b - a * c;
         bezout(sp, disc, s, u2, v2);
         n  = word_div(a, s);
         l  = n * a;
         v2 = word_rem(v2, l);
         k  = word_rem(v1 * u2, l);
         k  = word_rem(k * a, l);
         k  = k + word_rem(v2 * b, l);
         k  = word_rem(k * c, l);
         k  = l - k;
         c  = c * s;
      end
      t = n * k;
      r.cube_a = 60'(n * l);
      r.cube_b = t * 2 + b;
      r.cube_c = word_div((t + b) * k + c, l);
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      mismatches++;
      $display("mismatch on cube %0d: %s got %h, expected %h", cubes_seen, what, got, want);
   endtask

   // Offer one form and hold it until the transfer; queue its cube.
   task automatic send_form(input form_type f, input bit typed, input cube_type typed_cube);
      cube_type predicted;
      bit fast;
      cube_form(f, predicted, fast);
      if (typed && predicted != typed_cube)
         $display("note: typed row %0d disagrees with predictor", forms_sent);
      cube_queue.push_back(typed ? typed_cube : predicted);
      fast_forms += fast;
      req_tdata  <= {7'b0, f};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      forms_sent++;
      // idle after the transfer, or keep tvalid high for the next form
      if (!calm && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Random form: mostly moderate sizes, extremes sprinkled in.
   function automatic form_type random_form();
      form_type f;
      case ($urandom_range(4))
         0: begin
            f.form_a = 20'($urandom_range(1, 20'hFFFFF));
            f.form_b = 21'($urandom);
            f.form_c = {8'($urandom), 32'($urandom)};
         end
         1: begin
            f.form_a = 20'($urandom_range(1, 64));
            f.form_b = 21'($urandom_range(0, 128) - 64);
            f.form_c = 40'($urandom_range(1, 1000));
         end
         2: begin
            f.form_a = 20'($urandom_range(1, 4096));
            f.form_b = 21'($urandom);
            f.form_c = 40'($urandom);
         end
         default: begin
            // share a common factor so the slow path is taken
            f.form_a = 20'($urandom_range(1, 2048) * 6);
            f.form_b = 21'($urandom_range(0, 4000) * 2 - 4000);
            f.form_c = {8'($urandom), 32'($urandom)};
         end
      endcase
      if (f.form_a == 0) f.form_a = 20'd1;
      if (f.form_b == 21'h100000) f.form_b = 21'h100001;
      if (f.form_c == 0) f.form_c = 40'd1;
      return f;
   endfunction

   // Receiver: random stall, field-by-field compare against the oldest cube.
   always @(posedge clock) begin
      cube_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[187:0];
            if (cube_queue.size() == 0) begin
               report("unexpected cube", rsp_tdata[63:0], 64'd0);
            end else begin
               want = cube_queue.pop_front();
               if (got.cube_a !== want.cube_a) report("cube_a", 64'(got.cube_a), 64'(want.cube_a));
               if (got.cube_b !== want.cube_b) report("cube_b", got.cube_b, want.cube_b);
               if (got.cube_c !== want.cube_c) report("cube_c", got.cube_c, want.cube_c);
               if (rsp_tdata[191:188] !== 4'b0) report("fill", 64'(rsp_tdata[191:188]), 64'd0);
            end
            cubes_seen++;
         end
         rsp_tready <= calm || ($urandom_range(99) >= 23);
      end
   end

   // Directed table: extremes, both paths, a negative b, wrapping products.
   row_type directed[$] = '{
      '{20'd1,       21'd1,        40'd1,             1'b1, '{64'd1, 64'd1, 60'd1}},
      '{20'd1,       21'h1FFFFF,   40'd1,             1'b0, '0},
      '{20'd1,       21'd0,        40'd1,             1'b0, '0},
      '{20'd2,       21'd1,        40'd3,             1'b0, '0},
      '{20'd2,       21'd2,        40'd5,             1'b0, '0},
      '{20'd3,       21'h1FFFFD,   40'd7,             1'b0, '0},
      '{20'd12,      21'd6,        40'd100,           1'b0, '0},
      '{20'hFFFFF,   21'd1,        40'd1,             1'b0, '0},
      '{20'hFFFFF,   21'h0FFFFF,   40'hFF_FFFF_FFFF,  1'b0, '0},
      '{20'hFFFFF,   21'h100001,   40'hFF_FFFF_FFFF,  1'b0, '0},
      '{20'd1,       21'h0FFFFF,   40'hFF_FFFF_FFFF,  1'b0, '0},
      '{20'd1,       21'h100001,   40'd1,             1'b0, '0},
      '{20'h80000,   21'h080000,   40'h80_0000_0000,  1'b0, '0},
      '{20'h55555,   21'h0AAAAA,   40'h55_5555_5555,  1'b0, '0},
      '{20'hAAAAA,   21'h155555,   40'hAA_AAAA_AAAA,  1'b0, '0},
      '{20'd1000,    21'd500,      40'd250001,        1'b0, '0},
      '{20'd7,       21'd0,        40'h10_0000_0000,  1'b0, '0},
      '{20'd30030,   21'd2310,     40'd77,            1'b0, '0}
   };

   initial begin
      form_type f;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         f.form_a = directed[i].a;
         f.form_b = directed[i].b;
         f.form_c = directed[i].c;
         send_form(f, directed[i].typed, directed[i].cube);
      end
      for (int i = 0; i < RANDOM_FORMS; i++) begin
         if (i == RANDOM_FORMS / 3) calm = 1'b1;
         if (i == RANDOM_FORMS / 2) calm = 1'b0;
         if (i == RANDOM_FORMS / 4) begin
            // hold off until every outstanding cube has come back
            req_tvalid <= 1'b0;
            do @(posedge clock); while (cube_queue.size() != 0);
         end
         send_form(random_form(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (cube_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d forms, %0d on the coprime fast path, %0d cubes checked",
               forms_sent, fast_forms, cubes_seen);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Hard stop, with a wide margin over the whole run.
   initial begin
      repeat (200_000_000) @(posedge clock);
      $display("timeout with %0d cubes outstanding", cube_queue.size());
      $display("tb: failure");
      $finish;
   end

endmodule
